// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

  localparam int unsigned MaxLine    = 4096;
  localparam int unsigned MaxStride  = 64;
  localparam int unsigned IdxW       = $clog2(MaxLine);
  localparam int unsigned PhW        = $clog2(MaxStride);
  localparam int unsigned StrideW    = 7;
  localparam int unsigned ZW         = 16;
  localparam int unsigned RgbW       = 24;
  localparam int unsigned FocW       = 24;
  localparam int unsigned CenW       = 20;
  localparam int unsigned PosW       = 34;
  localparam int unsigned MagW       = 20;
  localparam int unsigned ProdW      = MagW + ZW;
  localparam int unsigned DvdW       = ProdW + 4;
  localparam int unsigned QW         = 33;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DivCntW    = $clog2(DvdW);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_DEPTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DEPTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_X   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_Y   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_INCL_RGB  = 3'd7;

  // divider job select
  localparam logic [1:0] DIV_X    = 2'd0;
  localparam logic [1:0] DIV_Y    = 2'd1;
  localparam logic [1:0] DIV_GREY = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_y;
    logic       div_start;
    logic       cap;
    logic [1:0] sel;
    logic       out_load;
  } dpd_cmd_t;

  typedef struct packed {
    logic kept;
    logic eof;
    logic grey;
    logic div_done;
  } dpd_sts_t;

endpackage

// ===== rtl/dpd_ifs.sv =====
interface dpd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_raw;
  logic [23:0] color_rgb;
  logic        color_fresh;
  logic        start_of_frame;
  logic        end_of_row;
  logic        end_of_frame;
  modport source (output valid, depth_raw, color_rgb, color_fresh, start_of_frame,
                  end_of_row, end_of_frame, input ready);
  modport sink (input valid, depth_raw, color_rgb, color_fresh, start_of_frame,
                end_of_row, end_of_frame, output ready);
endinterface

interface dpd_pt_if;
  logic        valid;
  logic        ready;
  logic [33:0] point_x;
  logic [33:0] point_y;
  logic [15:0] point_z;
  logic [23:0] point_rgb;
  logic        point_valid;
  logic        frame_end;
  modport source (output valid, point_x, point_y, point_z, point_rgb, point_valid,
                  frame_end, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_rgb, point_valid,
                frame_end, output ready);
endinterface

interface dpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/depth_pixel_deprojection_core.sv =====
// Depth pixel deprojection core.
// pix_i  : sink of raster-order raw depth pixels with frame/row markers.
// pt_o   : source of result items, one per kept pixel or frame-end pixel.
// cfg_i  : register write channel, always ready; write only while idle.
// A pixel transfer is taken when the core is idle. A dropped pixel with no
// frame end goes from decode back to idle; a frame end without a point goes
// through decode and the output state. A kept pixel takes two multiply passes
// and two 40-step restoring divides by the focal lengths (one bit per cycle,
// shared divider), plus a third divide for the grey level when colour is
// stale in colour mode. The shared divider sets the rate.
// Results sit in an output register, so the next pixel is taken while a
// finished point still waits; if the receiver stalls, a second finished
// point holds the core until the register frees.
// Reset clears the raster counters, output valid and loads the register
// defaults; no clearing pass is needed.
module depth_pixel_deprojection_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpd_pix_if.sink   pix_i,
  dpd_pt_if.source  pt_o,
  dpd_cfg_if.sink   cfg_i
);
  import dpd_pkg::*;

  dpd_cmd_t cmd;
  dpd_sts_t sts;

  // config writes are always accepted
  assign cfg_i.ready = 1'b1;

  dpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (pt_o.valid),
    .out_ready_i (pt_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: counters, multiplier, divider, output register
  dpd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .depth_raw_i      (pix_i.depth_raw),
    .color_rgb_i      (pix_i.color_rgb),
    .color_fresh_i    (pix_i.color_fresh),
    .start_of_frame_i (pix_i.start_of_frame),
    .end_of_row_i     (pix_i.end_of_row),
    .end_of_frame_i   (pix_i.end_of_frame),
    .point_x_o        (pt_o.point_x),
    .point_y_o        (pt_o.point_y),
    .point_z_o        (pt_o.point_z),
    .point_rgb_o      (pt_o.point_rgb),
    .point_valid_o    (pt_o.point_valid),
    .frame_end_o      (pt_o.frame_end)
  );
endmodule

// ===== rtl/dpd_div.sv =====
module dpd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dpd_pkg::DvdW-1:0]   dividend_i,
  input  logic [dpd_pkg::FocW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [dpd_pkg::DvdW-1:0]   quot_o
);
  import dpd_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0]    sh_q, sh_d;
  logic [FocW-1:0]    rem_q, rem_d, dvs_q, dvs_d;
  logic [FocW:0]      trial;
  logic               ge;

  // restoring, one quotient bit per cycle
  assign trial = {rem_q, sh_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      sh_d  = {sh_q[DvdW-2:0], ge};
      rem_d = ge ? FocW'(trial - {1'b0, dvs_q}) : trial[FocW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
endmodule

// ===== rtl/dpd_ctrl.sv =====
module dpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dpd_pkg::dpd_sts_t sts_i,
  output dpd_pkg::dpd_cmd_t cmd_o
);
  import dpd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_MX   = 4'd2;
  localparam logic [3:0] S_SX   = 4'd3;
  localparam logic [3:0] S_WX   = 4'd4;
  localparam logic [3:0] S_MY   = 4'd5;
  localparam logic [3:0] S_SY   = 4'd6;
  localparam logic [3:0] S_WY   = 4'd7;
  localparam logic [3:0] S_SG   = 4'd8;
  localparam logic [3:0] S_WG   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] st_q, st_d;
  logic       ov_q, ov_d;
  logic       slot_free;

  assign slot_free  = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    cmd_o.sel = DIV_X;
    ov_d  = ov_q && !out_ready_i;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.kept)     st_d = S_MX;
        else if (sts_i.eof) st_d = S_OUT;
        else                st_d = S_IDLE;
      end
      S_MX: begin
        cmd_o.mul_en = 1'b1;
        st_d = S_SX;
      end
      S_SX: begin
        cmd_o.div_start = 1'b1;
        st_d = S_WX;
      end
      S_WX: begin
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          st_d = S_MY;
        end
      end
      S_MY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_y  = 1'b1;
        st_d = S_SY;
      end
      S_SY: begin
        cmd_o.sel = DIV_Y;
        cmd_o.div_start = 1'b1;
        st_d = S_WY;
      end
      S_WY: begin
        cmd_o.sel = DIV_Y;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          st_d = sts_i.grey ? S_SG : S_OUT;
        end
      end
      S_SG: begin
        cmd_o.sel = DIV_GREY;
        cmd_o.div_start = 1'b1;
        st_d = S_WG;
      end
      S_WG: begin
        cmd_o.sel = DIV_GREY;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule

// ===== rtl/dpd_dp.sv =====
module dpd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dpd_pkg::dpd_cmd_t             cmd_i,
  output dpd_pkg::dpd_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [dpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpd_pkg::FocW-1:0]      cfg_data_i,
  input  logic [dpd_pkg::ZW-1:0]        depth_raw_i,
  input  logic [dpd_pkg::RgbW-1:0]      color_rgb_i,
  input  logic                          color_fresh_i,
  input  logic                          start_of_frame_i,
  input  logic                          end_of_row_i,
  input  logic                          end_of_frame_i,
  output logic [dpd_pkg::PosW-1:0]      point_x_o,
  output logic [dpd_pkg::PosW-1:0]      point_y_o,
  output logic [dpd_pkg::ZW-1:0]        point_z_o,
  output logic [dpd_pkg::RgbW-1:0]      point_rgb_o,
  output logic                          point_valid_o,
  output logic                          frame_end_o
);
  import dpd_pkg::*;

  // configuration
  logic [ZW-1:0]      min_q, max_q;
  logic [FocW-1:0]    fx_q, fy_q;
  logic [CenW-1:0]    cx_q, cy_q;
  logic [StrideW-1:0] str_q;
  logic               incl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= ZW'(50);
      max_q  <= ZW'(3000);
      fx_q   <= FocW'(153600);
      fy_q   <= FocW'(153600);
      cx_q   <= CenW'(81920);
      cy_q   <= CenW'(61440);
      str_q  <= StrideW'(1);
      incl_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DEPTH: min_q  <= cfg_data_i[ZW-1:0];
        CFG_MAX_DEPTH: max_q  <= cfg_data_i[ZW-1:0];
        CFG_FOCAL_X:   fx_q   <= cfg_data_i;
        CFG_FOCAL_Y:   fy_q   <= cfg_data_i;
        CFG_CENTER_X:  cx_q   <= cfg_data_i[CenW-1:0];
        CFG_CENTER_Y:  cy_q   <= cfg_data_i[CenW-1:0];
        CFG_STRIDE:    str_q  <= cfg_data_i[StrideW-1:0];
        CFG_INCL_RGB:  incl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // raster counters
  logic [IdxW-1:0]    row_q, col_q, row_d, col_d, row_c, col_c;
  logic [PhW-1:0]     rph_q, cph_q, rph_d, cph_d, rph_c, cph_c;
  logic [StrideW-1:0] s_eff;
  logic               kept_c;

  assign s_eff = (str_q == '0) ? StrideW'(1) :
                 (str_q > StrideW'(MaxStride)) ? StrideW'(MaxStride) : str_q;

  always_comb begin
    row_c = start_of_frame_i ? '0 : row_q;
    col_c = start_of_frame_i ? '0 : col_q;
    rph_c = start_of_frame_i ? '0 : rph_q;
    cph_c = start_of_frame_i ? '0 : cph_q;
    kept_c = (rph_c == '0) && (cph_c == '0) && (depth_raw_i != '0) &&
             (depth_raw_i >= min_q) && (depth_raw_i <= max_q);
    row_d = row_c;
    col_d = col_c;
    rph_d = rph_c;
    cph_d = cph_c;
    if (end_of_frame_i) begin
      row_d = '0;
      col_d = '0;
      rph_d = '0;
      cph_d = '0;
    end else if (end_of_row_i) begin
      col_d = '0;
      cph_d = '0;
      row_d = (&row_c) ? row_c : row_c + 1'b1;
      rph_d = ({1'b0, rph_c} + 1'b1 >= s_eff) ? '0 : rph_c + 1'b1;
    end else begin
      col_d = (&col_c) ? col_c : col_c + 1'b1;
      cph_d = ({1'b0, cph_c} + 1'b1 >= s_eff) ? '0 : cph_c + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      rph_q <= '0;
      cph_q <= '0;
    end else if (cmd_i.load) begin
      row_q <= row_d;
      col_q <= col_d;
      rph_q <= rph_d;
      cph_q <= cph_d;
    end
  end

  // item registers
  logic [MagW-1:0] px, py, magx_c, magy_c, magx_q, magy_q;
  logic            negx_c, negy_c, negx_q, negy_q;
  logic [ZW-1:0]   z_q;
  logic [RgbW-1:0] rgb_q;
  logic            fresh_q, eof_q, kept_q;

  assign px     = {col_c, 8'd0};
  assign py     = {row_c, 8'd0};
  assign negx_c = px < cx_q;
  assign negy_c = py < cy_q;
  assign magx_c = negx_c ? cx_q - px : px - cx_q;
  assign magy_c = negy_c ? cy_q - py : py - cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      z_q     <= depth_raw_i;
      rgb_q   <= color_rgb_i;
      fresh_q <= color_fresh_i;
      eof_q   <= end_of_frame_i;
      kept_q  <= kept_c;
      magx_q  <= magx_c;
      magy_q  <= magy_c;
      negx_q  <= negx_c;
      negy_q  <= negy_c;
    end
  end

  // shared multiplier, then shared divider
  logic [ProdW-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= (cmd_i.mul_y ? magy_q : magx_q) * z_q;
  end

  logic [FocW-1:0] fx_eff, fy_eff, span, dvs;
  logic [ZW-1:0]   dz, sp16;
  logic [RgbW-1:0] gnum;
  logic [DvdW-1:0] dvd, quot;
  logic            div_done;

  assign fx_eff = (fx_q[FocW-1:8] == '0) ? FocW'(256) : fx_q;
  assign fy_eff = (fy_q[FocW-1:8] == '0) ? FocW'(256) : fy_q;
  assign sp16   = max_q - min_q;
  assign span   = (sp16 == '0) ? FocW'(1) : FocW'(sp16);
  assign dz     = max_q - z_q;
  assign gnum   = RgbW'({dz, 8'd0}) - RgbW'(dz);

  always_comb begin
    case (cmd_i.sel)
      DIV_X:    begin dvd = {prod_q, 4'd0}; dvs = fx_eff; end
      DIV_Y:    begin dvd = {prod_q, 4'd0}; dvs = fy_eff; end
      DIV_GREY: begin dvd = DvdW'(gnum);    dvs = span;   end
      default:  begin dvd = '0;             dvs = FocW'(1); end
    endcase
  end

  dpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic [QW-1:0] qx_q, qy_q;
  logic [7:0]    g_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      case (cmd_i.sel)
        DIV_X:    qx_q <= quot[QW-1:0];
        DIV_Y:    qy_q <= quot[QW-1:0];
        DIV_GREY: g_q  <= quot[7:0];
        default: ;
      endcase
    end
  end

  // output register
  logic [PosW-1:0] sx, sy;
  logic [RgbW-1:0] rgb_sel;
  assign sx = negx_q ? PosW'(0) - PosW'(qx_q) : PosW'(qx_q);
  assign sy = negy_q ? PosW'(0) - PosW'(qy_q) : PosW'(qy_q);
  assign rgb_sel = !incl_q ? '0 : fresh_q ? rgb_q : {g_q, g_q, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      point_x_o     <= kept_q ? sx : '0;
      point_y_o     <= kept_q ? sy : '0;
      point_z_o     <= kept_q ? z_q : '0;
      point_rgb_o   <= kept_q ? rgb_sel : '0;
      point_valid_o <= kept_q;
      frame_end_o   <= eof_q;
    end
  end

  assign sts_o.kept     = kept_q;
  assign sts_o.eof      = eof_q;
  assign sts_o.grey     = incl_q && !fresh_q;
  assign sts_o.div_done = div_done;
endmodule

// ===== rtl/dpd_checker.sv =====
module dpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [33:0] point_x_i,
  input logic [15:0] point_z_i,
  input logic        point_valid_i,
  input logic        frame_end_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(point_z_i))
    else $error("result dropped under stall");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second pixel taken while busy");

  a_empty_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !point_valid_i |-> frame_end_i && point_z_i == 16'd0 &&
    point_x_i == 34'd0)
    else $error("empty result not a clean frame end");

  a_point_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && point_valid_i |-> point_z_i != 16'd0)
    else $error("point with zero depth");
endmodule

bind depth_pixel_deprojection_core dpd_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (pt_o.valid),
  .out_ready_i   (pt_o.ready),
  .point_x_i     (pt_o.point_x),
  .point_z_i     (pt_o.point_z),
  .point_valid_i (pt_o.point_valid),
  .frame_end_i   (pt_o.frame_end)
);
